// ===== hw/rtl/seed_map_xor_unmask_top_macros.svh =====
// ----------------------------------------------------------------------------
// Seed map XOR unmask assertion macros
// Shared wrappers for the concurrent checks of the unmask block.
// ----------------------------------------------------------------------------
`ifndef SEED_MAP_XOR_UNMASK_TOP_MACROS_SVH
`define SEED_MAP_XOR_UNMASK_TOP_MACROS_SVH

// Checks prop at every rising edge of clk while rst_n is high.
`define SMXU_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check, clocked by i_clk and held off by i_rst_n.
`define SMXU_ASSERT(label, prop, msg) \
    `SMXU_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

// ===== hw/rtl/smxu_pkg.sv =====
// ----------------------------------------------------------------------------
// Seed map XOR unmask package
// Seed table, edge bytes, walk state type and the single keystream step.
// ----------------------------------------------------------------------------
package smxu_pkg;

    localparam int POSITION_BITS = 32;
    localparam int SKIP_LOG2     = 15;

    localparam logic [POSITION_BITS-1:0] SKIP_PERIOD   = POSITION_BITS'(1) << SKIP_LOG2;
    localparam logic [POSITION_BITS-1:0] POSITION_ZERO = '0;
    localparam logic [POSITION_BITS-1:0] POSITION_MAX  = '1;

    localparam logic [7:0] EDGE_LEFT_BYTE  = 8'hC3;
    localparam logic [7:0] EDGE_RIGHT_BYTE = 8'hD8;

    localparam logic [3:0] COLUMN_RESET = 4'hF;
    localparam logic [3:0] ROW_RESET    = 4'd8;
    localparam logic [3:0] ROW_LEFT     = 4'd8;
    localparam logic [3:0] ROW_RIGHT    = 4'd7;
    localparam logic [2:0] COLUMN_LAST  = 3'd7;

    localparam logic [7:0] SEED_MAP [0:7][0:6] = '{
        '{8'h4a, 8'hd6, 8'hca, 8'h90, 8'h67, 8'hf7, 8'h52},
        '{8'h5e, 8'h95, 8'h23, 8'h9f, 8'h13, 8'h11, 8'h7e},
        '{8'h47, 8'h74, 8'h3d, 8'h90, 8'haa, 8'h3f, 8'h51},
        '{8'hc6, 8'h09, 8'hd5, 8'h9f, 8'hfa, 8'h66, 8'hf9},
        '{8'hf3, 8'hd6, 8'ha1, 8'h90, 8'ha0, 8'hf7, 8'hf0},
        '{8'h1d, 8'h95, 8'hde, 8'h9f, 8'h84, 8'h11, 8'hf4},
        '{8'h0e, 8'h74, 8'hbb, 8'h90, 8'hbc, 8'h3f, 8'h92},
        '{8'h00, 8'h09, 8'h5b, 8'h9f, 8'h62, 8'h66, 8'ha1}
    };

    typedef struct packed {
        logic [3:0] column;
        logic [3:0] row;
        logic       backward;
    } t_walk;

    typedef struct packed {
        t_walk      walk;
        logic [7:0] key;
    } t_key_step;

    localparam t_walk WALK_RESET = '{column: COLUMN_RESET, row: ROW_RESET, backward: 1'b0};

    // One keystream byte and the walk state that follows it.
    function automatic t_key_step key_step(input t_walk w);
        t_key_step s;
        logic [3:0] diff;
        s      = '{walk: w, key: 8'h00};
        diff   = ROW_LEFT - w.row;
        if (w.column[3]) begin
            s.walk.backward = 1'b0;
            s.walk.row      = {1'b0, diff[2:0]};
            s.key           = EDGE_LEFT_BYTE;
        end else if (w.column[2:0] == COLUMN_LAST) begin
            s.walk.backward = 1'b1;
            s.walk.row      = ROW_RIGHT - w.row;
            s.key           = EDGE_RIGHT_BYTE;
        end else begin
            s.key = SEED_MAP[w.row[2:0]][w.column[2:0]];
        end
        s.walk.column = s.walk.backward ? (w.column - 4'd1) : (w.column + 4'd1);
        return s;
    endfunction

endpackage

// ===== hw/rtl/seed_map_xor_unmask_top.sv =====
// ----------------------------------------------------------------------------
// Seed map XOR unmask top level
// Accepted beats are registered to the output. Throughput: one beat per cycle
// unless m_axis_tready stalls the output; the keystream step, its optional
// second step and the saturating position advance all fit between the walk
// state and the output register. Reset clears the walk, position and output
// valid; a start-of-file beat restarts the walk and position on its own.
// ----------------------------------------------------------------------------
`include "seed_map_xor_unmask_top_macros.svh"

module seed_map_xor_unmask_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] cipher_byte
    input  logic [0:0] s_axis_tuser,   // [0] start_of_file
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] plain_byte
    output logic [0:0] m_axis_tuser    // [0] position_overflow
);

    localparam int PB = smxu_pkg::POSITION_BITS;
    localparam int SL = smxu_pkg::SKIP_LOG2;

    smxu_pkg::t_walk     r_walk;
    smxu_pkg::t_walk     n_walk;
    logic [PB-1:0]       r_position;
    logic [PB-1:0]       n_position;
    logic                r_saturated;
    logic                n_saturated;
    logic                r_out_valid;
    logic [7:0]          r_out_data;
    logic                r_out_overflow;

    smxu_pkg::t_walk     walk0;
    smxu_pkg::t_key_step step1;
    smxu_pkg::t_key_step step2;
    logic [PB-1:0]       pos0;
    logic [PB-1:0]       pos1;
    logic                sat0;
    logic                sat1;
    logic                skip;
    logic                at_max0;
    logic                at_max1;
    logic [7:0]          key;
    logic                in_fire;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_comb begin
        walk0   = s_axis_tuser[0] ? smxu_pkg::WALK_RESET : r_walk;
        pos0    = s_axis_tuser[0] ? smxu_pkg::POSITION_ZERO : r_position;
        sat0    = s_axis_tuser[0] ? 1'b0 : r_saturated;
        skip    = (pos0 == smxu_pkg::SKIP_PERIOD) || ((&pos0[SL-1:0]) && (|pos0[PB-1:SL]));
        step1   = smxu_pkg::key_step(walk0);
        step2   = smxu_pkg::key_step(step1.walk);
        at_max0 = (pos0 == smxu_pkg::POSITION_MAX);
        if (skip) begin
            pos1 = at_max0 ? pos0 : pos0 + PB'(1);
            sat1 = sat0 || at_max0;
            key  = step2.key;
            n_walk = step2.walk;
        end else begin
            pos1 = pos0;
            sat1 = sat0;
            key  = step1.key;
            n_walk = step1.walk;
        end
        at_max1     = (pos1 == smxu_pkg::POSITION_MAX);
        n_position  = at_max1 ? pos1 : pos1 + PB'(1);
        n_saturated = sat1 || at_max1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk      <= smxu_pkg::WALK_RESET;
            r_position  <= smxu_pkg::POSITION_ZERO;
            r_saturated <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_walk      <= n_walk;
                r_position  <= n_position;
                r_saturated <= n_saturated;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_data     <= s_axis_tdata ^ key;
            r_out_overflow <= n_saturated;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_overflow;

    `SMXU_ASSERT(a_sat_holds_max, r_saturated |-> (r_position == smxu_pkg::POSITION_MAX), "saturated flag set below the top position")
    `SMXU_ASSERT(a_start_restarts, (in_fire && s_axis_tuser[0]) |=> (r_position == PB'(1)), "start-of-file beat did not restart the position")
    `SMXU_ASSERT(a_row_eight_only_at_start, r_walk.row[3] |-> (r_walk.column == smxu_pkg::COLUMN_RESET), "row eight seen away from the left edge")
    `SMXU_ASSERT(a_column_range, (!r_walk.column[3]) || (r_walk.column == smxu_pkg::COLUMN_RESET), "column left its range")

endmodule
